[sv/sbe_pkg.sv]
`timescale 1ns / 1ps
package sbe_pkg;

  localparam int MAX_LEN     = 1024;
  localparam int MAX_EXT     = 256;
  localparam int SAMPLE_BITS = 32;
  localparam int IDX_W       = $clog2(MAX_LEN);
  localparam int CNT_W       = IDX_W + 1;
  localparam int POS_W       = 11;
  localparam int EXT_W       = 9;
  localparam int PER_W       = CNT_W + 1;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_EXT  = 2'd1;

  typedef struct packed {
    logic [1:0]             kind;
    logic [SAMPLE_BITS-1:0] sample;
    logic [POS_W-1:0]       position;
  } sbe_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_res;
    logic [POS_W-1:0]       extended_length;
    logic [1:0]             status;
  } sbe_out_t;

  function automatic logic [EXT_W-1:0] eff_ext(input logic [EXT_W-1:0] ext);
    eff_ext = (ext > EXT_W'(MAX_EXT)) ? EXT_W'(MAX_EXT) : ext;
  endfunction

  function automatic logic [PER_W-1:0] base_len(input logic [CNT_W-1:0] n,
                                                 input logic mode);
    base_len = mode ? PER_W'(n) : PER_W'(n) + PER_W'(n[0]);
  endfunction

  function automatic logic [POS_W-1:0] ext_len(input logic [CNT_W-1:0] n,
                                               input logic mode,
                                               input logic [EXT_W-1:0] ext);
    logic [PER_W:0] sum;
    sum = {1'b0, base_len(n, mode)} + (PER_W+1)'({eff_ext(ext), 1'b0});
    ext_len = (n == '0) ? '0 : sum[POS_W-1:0];
  endfunction

endpackage

[sv/signal_boundary_extension_core.sv]
`timescale 1ns / 1ps
// Boundary extension store: clear and load words build a signal of up to 1024 raw 32-bit
// samples in a single-port RAM, and fetch words return the sample at a position of the
// periodically or symmetrically extended signal. Every word gives exactly one result word.
// One item is in flight at a time: clear, load and unused kinds go straight from accept
// to the result stage, a fetch that is in range passes through the iterative remainder by
// the period (S_DIV), the RAM read (S_ADDR) and the registered result (S_FINISH), and a
// fetch that is flagged goes straight to the result stage. A result held in the output
// register does not block the next accept, but the block waits to deliver before
// finishing the following item.
// Configuration (mode, extension) must be written only while no item is in flight; the block does not enforce it.
module signal_boundary_extension_core import sbe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  sbe_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sbe_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [EXT_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DIV    = 2'd1;
  localparam logic [1:0] S_ADDR   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [SAMPLE_BITS-1:0] store [MAX_LEN];
  logic [SAMPLE_BITS-1:0] mem_q;

  logic [1:0]       state;
  logic [CNT_W-1:0] count;
  logic             mode;
  logic [EXT_W-1:0] ext;
  logic [1:0]       status;
  logic             use_mem;
  logic             neg;
  logic [PER_W-1:0] period;

  logic             accept;
  logic             deliver;
  logic             div_start;
  logic             div_done;
  logic [PER_W-1:0] rem;
  logic [PER_W-1:0] q;
  logic [PER_W-1:0] idx_wide;
  logic [POS_W-1:0] cur_len;
  logic [EXT_W-1:0] a;
  logic [POS_W-1:0] ax;
  logic [POS_W-1:0] div_dividend;
  logic [PER_W-1:0] div_divisor;
  logic             is_fetch_ok;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign deliver   = (state == S_FINISH) && (!out_valid || !out_stall);
  assign a         = eff_ext(ext);
  assign ax        = POS_W'(a);
  assign cur_len   = ext_len(count, mode, ext);

  assign is_fetch_ok = (in_data.kind == KIND_FETCH) && (count != '0) &&
                       (in_data.position < cur_len);
  assign div_start   = accept && is_fetch_ok;

  assign div_dividend = (in_data.position < ax) ? ax - in_data.position
                                                : in_data.position - ax;
  assign div_divisor  = mode ? {count, 1'b0} : base_len(count, mode);

  sbe_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (rem)
  );

  // non-negative residue, then fold into the stored range
  always_comb begin
    q = (neg && rem != '0) ? period - rem : rem;
    if (mode) begin
      idx_wide = (q < PER_W'(count)) ? q : {count, 1'b0} - PER_W'(1) - q;
    end else begin
      idx_wide = (q >= PER_W'(count)) ? PER_W'(count) - PER_W'(1) : q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.kind == KIND_LOAD && count < CNT_W'(MAX_LEN)) begin
      store[count[IDX_W-1:0]] <= in_data.sample;
    end
    if (state == S_ADDR) begin
      mem_q <= store[idx_wide[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      ext  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE: mode <= cfg_data[0];
        REG_EXT:  ext  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= deliver || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= is_fetch_ok ? S_DIV : S_FINISH;
            unique case (in_data.kind)
              KIND_CLEAR: count <= '0;
              KIND_LOAD: begin
                if (count < CNT_W'(MAX_LEN)) begin
                  count <= count + CNT_W'(1);
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_ADDR;
          end
        end
        S_ADDR: state <= S_FINISH;
        S_FINISH: begin
          // hold until the output register is free
          if (deliver) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      use_mem  <= is_fetch_ok;
      neg      <= in_data.position < ax;
      period   <= div_divisor;
      priority if (in_data.kind == KIND_LOAD && count >= CNT_W'(MAX_LEN)) begin
        status <= ST_FULL;
      end else if (in_data.kind == KIND_FETCH && count == '0) begin
        status <= ST_EMPTY;
      end else if (in_data.kind == KIND_FETCH && in_data.position >= cur_len) begin
        status <= ST_RANGE;
      end else begin
        status <= ST_OK;
      end
    end
    if (deliver) begin
      out_data.sample_res      <= use_mem ? mem_q : '0;
      out_data.extended_length <= cur_len;
      out_data.status          <= status;
    end
  end

endmodule

[sv/sbe_rem.sv]
`timescale 1ns / 1ps
module sbe_rem import sbe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [POS_W-1:0] dividend,
  input  logic [PER_W-1:0] divisor,
  output logic             done,
  output logic [PER_W-1:0] rem
);

  localparam int STEP_W = $clog2(POS_W + 1);

  logic [POS_W-1:0]  dvd;
  logic [STEP_W-1:0] steps;
  logic [PER_W-1:0]  shifted;

  // restoring remainder, one dividend bit a cycle
  assign shifted = {rem[PER_W-2:0], dvd[POS_W-1]};
  assign done    = (steps == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(POS_W);
    end else if (!done) begin
      steps <= steps - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
    end else if (!done) begin
      rem <= (shifted >= divisor) ? shifted - divisor : shifted;
      dvd <= {dvd[POS_W-2:0], 1'b0};
    end
  end

endmodule

[dv/tb_signal_boundary_extension_core.sv]
`timescale 1ns / 1ps
module tb_signal_boundary_extension_core;
  import sbe_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [1:0] REG_SPARE  = 2'd3;
  localparam int         MAX_GAP    = 17;

  // Tracks the stored signal and the configuration, and holds the result word
  // due for every accepted input word.
  class boundary_tracker;
    logic [SAMPLE_BITS-1:0] samples [MAX_LEN];
    int                     count;
    bit                     mirror;
    int                     ext_reg;
    sbe_out_t               due [$];
    int                     errors;

    function new();
      count   = 0;
      mirror  = 1'b0;
      ext_reg = 0;
      errors  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [EXT_W-1:0] val);
      if (idx == REG_MODE) begin
        mirror = val[0];
      end else if (idx == REG_EXT) begin
        ext_reg = int'(val);
      end
    endfunction

    function int clipped_ext();
      return (ext_reg > MAX_EXT) ? MAX_EXT : ext_reg;
    endfunction

    function int total_length();
      int base;
      base = mirror ? count : count + (count & 1);
      return (count == 0) ? 0 : base + 2 * clipped_ext();
    endfunction

    function void note_word(sbe_in_t w);
      sbe_out_t r;
      int       a;
      int       per;
      int       q;
      int       idx;
      r = '0;
      case (w.kind)
        KIND_CLEAR: begin
          count = 0;
        end
        KIND_LOAD: begin
          if (count >= MAX_LEN) begin
            r.status = ST_FULL;
          end else begin
            samples[count] = w.sample;
            count++;
          end
        end
        KIND_FETCH: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else if (int'(w.position) >= total_length()) begin
            r.status = ST_RANGE;
          end else begin
            a   = clipped_ext();
            per = mirror ? 2 * count : count + (count & 1);
            q   = ((int'(w.position) % per) + per - (a % per)) % per;
            if (!mirror) begin
              // the padding slot of an odd signal repeats the last sample
              idx = (q >= count) ? count - 1 : q;
            end else begin
              idx = (q < count) ? q : 2 * count - 1 - q;
            end
            r.sample_res = samples[idx];
          end
        end
        default: begin
        end
      endcase
      r.extended_length = POS_W'(total_length());
      due.push_back(r);
    endfunction

    function void check_word(sbe_out_t got);
      sbe_out_t want;
      if (due.size() == 0) begin
        $display("%0t: result word with none due: %h", $time, got);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got.sample_res !== want.sample_res) begin
        $display("%0t: sample_res expected %h actual %h", $time, want.sample_res,
                 got.sample_res);
        errors++;
      end
      if (got.extended_length !== want.extended_length) begin
        $display("%0t: extended_length expected %0d actual %0d", $time,
                 want.extended_length, got.extended_length);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  sbe_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  sbe_out_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = REG_MODE;
  logic [EXT_W-1:0] cfg_data = '0;

  boundary_tracker tracker;
  bit              quiet = 1'b0;
  int              hold_cycles = 0;
  int              words_sent = 0;

  signal_boundary_extension_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Offer one word, hold it until accepted, then idle for a random gap (none when quiet) before the next one.
  task automatic send_word(logic [1:0] kind, logic [SAMPLE_BITS-1:0] sample,
                           logic [POS_W-1:0] pos);
    sbe_in_t w;
    int      gap;
    w.kind     = kind;
    w.sample   = sample;
    w.position = pos;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_word(w);
    if (kind != KIND_SPARE) words_sent++;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [EXT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  task automatic configure(bit m, int e);
    wait_idle();
    write_reg(REG_MODE, EXT_W'(m));
    write_reg(REG_EXT, EXT_W'(e));
    cfg_valid <= 1'b0;
  endtask

  task automatic fetch_any();
    int len;
    len = tracker.total_length();
    if (len == 0 || $urandom_range(0, 6) == 0) begin
      send_word(KIND_FETCH, $urandom, POS_W'($urandom_range(0, 2047)));
    end else begin
      send_word(KIND_FETCH, $urandom, POS_W'($urandom_range(0, len - 1)));
    end
  endtask

  // Drain side: stall for hold_cycles when set, else for a drawn number of cycles, before each result word.
  initial begin : drain
    int k;
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        k = hold_cycles;
        hold_cycles = 0;
      end else begin
        k = quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      tracker.check_word(out_data);
    end
  end

  initial begin : stimulus
    int seg_len;
    int n_fetch;
    int ext_pick;
    int start_count;
    tracker = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset configuration is periodic with no extension.
    send_word(KIND_FETCH, 32'h0, 11'd0);
    send_word(KIND_SPARE, 32'hFFFF_FFFF, 11'h7FF);
    send_word(KIND_LOAD, 32'h0000_0000, 11'd0);
    send_word(KIND_LOAD, 32'hFFFF_FFFF, 11'h7FF);
    send_word(KIND_LOAD, 32'h5A5A_C3C3, 11'd0);
    send_word(KIND_FETCH, 32'h0, 11'd0);
    send_word(KIND_FETCH, 32'h0, 11'd2);
    send_word(KIND_FETCH, 32'h0, 11'd3);
    send_word(KIND_FETCH, 32'h0, 11'd4);
    send_word(KIND_FETCH, 32'h0, 11'h7FF);
    send_word(KIND_CLEAR, 32'hFFFF_FFFF, 11'h7FF);
    send_word(KIND_FETCH, 32'h0, 11'd0);
    send_word(KIND_LOAD, 32'h8000_0001, 11'd0);
    send_word(KIND_FETCH, 32'h0, 11'd1);

    // Oversized extension saturates; the unused register index is ignored.
    wait_idle();
    write_reg(REG_SPARE, 9'h1FF);
    write_reg(REG_MODE, 9'd1);
    write_reg(REG_EXT, 9'h1FF);
    cfg_valid <= 1'b0;
    send_word(KIND_LOAD, 32'h7FFF_FFFE, 11'd0);
    send_word(KIND_FETCH, 32'h0, 11'd0);
    send_word(KIND_FETCH, 32'h0, 11'd255);
    send_word(KIND_FETCH, 32'h0, 11'd256);
    send_word(KIND_FETCH, 32'h0, 11'd513);
    send_word(KIND_FETCH, 32'h0, 11'd514);
    configure(1'b0, MAX_EXT);
    send_word(KIND_FETCH, 32'h0, 11'd0);
    send_word(KIND_FETCH, 32'h0, 11'd515);

    // Fill to capacity with the drain held off so the input backs up.
    configure(1'b1, MAX_EXT);
    quiet = 1'b1;
    hold_cycles = 400;
    send_word(KIND_CLEAR, 32'h0, 11'd0);
    repeat (MAX_LEN + 2) send_word(KIND_LOAD, $urandom, POS_W'($urandom));
    send_word(KIND_FETCH, 32'h0, 11'd0);
    send_word(KIND_FETCH, 32'h0, 11'd1535);
    send_word(KIND_FETCH, 32'h0, 11'd1536);
    send_word(KIND_FETCH, 32'h0, 11'h7FF);
    quiet = 1'b0;
    repeat (10) fetch_any();
    configure(1'b0, MAX_EXT);
    send_word(KIND_FETCH, 32'h0, 11'd1535);
    send_word(KIND_FETCH, 32'h0, 11'd1536);
    repeat (5) fetch_any();

    // Random segments: mostly a clear, a short signal, then fetches.
    start_count = words_sent;
    while (words_sent - start_count < 200) begin
      ext_pick = $urandom_range(0, 7);
      case (ext_pick)
        0: configure(1'($urandom_range(0, 1)), 0);
        1: configure(1'($urandom_range(0, 1)), MAX_EXT);
        2: configure(1'($urandom_range(0, 1)), $urandom_range(MAX_EXT + 1, 511));
        3: configure(1'($urandom_range(0, 1)), $urandom_range(0, MAX_EXT));
        default: configure(1'($urandom_range(0, 1)), $urandom_range(0, 12));
      endcase
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) != 0) send_word(KIND_CLEAR, $urandom, POS_W'($urandom));
      case ($urandom_range(0, 9))
        0:       seg_len = 0;
        1:       seg_len = $urandom_range(25, 200);
        default: seg_len = $urandom_range(1, 24);
      endcase
      repeat (seg_len) begin
        case ($urandom_range(0, 19))
          0:       send_word(KIND_SPARE, $urandom, POS_W'($urandom));
          1:       fetch_any();
          default: ;
        endcase
        send_word(KIND_LOAD, $urandom, POS_W'($urandom));
      end
      n_fetch = $urandom_range(4, 30);
      repeat (n_fetch) begin
        case ($urandom_range(0, 29))
          0:       send_word(KIND_SPARE, $urandom, POS_W'($urandom));
          1:       send_word(KIND_LOAD, $urandom, POS_W'($urandom));
          default: fetch_any();
        endcase
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    tracker.errors += tracker.due.size();
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/sbe_pkg.sv
sv/sbe_rem.sv
sv/signal_boundary_extension_core.sv
dv/tb_signal_boundary_extension_core.sv
